@@ design/covariance_to_correlation_unit_macros.svh @@
// Assertion macros for the covariance-to-correlation unit checker
`ifndef COVARIANCE_TO_CORRELATION_UNIT_MACROS_SVH
`define COVARIANCE_TO_CORRELATION_UNIT_MACROS_SVH

// Concurrent assertion clocked on clk, disabled during reset
`define C2C_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// Antecedent in one cycle implies the consequent in the next
`define C2C_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ design/c2c_pkg.sv @@
// Package: constants, types and controller interface structs for the c2c unit
`timescale 1ns / 1ps
package c2c_pkg;
	localparam int DIM_DEF       = 16;
	localparam int FRAC_BITS_DEF = 16;
	localparam int IDX_W         = 4;
	localparam int VAL_W         = 32;
	localparam int PROD_W        = 64;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_READ  = 1'b1;

	// Store address select
	localparam logic [1:0] ADDR_ELEM = 2'd0;
	localparam logic [1:0] ADDR_DI   = 2'd1;
	localparam logic [1:0] ADDR_DJ   = 2'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic ram_we;
		logic ram_re;
		logic [1:0] addr_sel;
		logic cap_idx;
		logic cap_elem;
		logic cap_di;
		logic cap_dj;
		logic mul_start;
		logic mul_step;
		logic sqrt_start;
		logic sqrt_step;
		logic div_start;
		logic div_step;
		logic res_zero;
		logic res_final;
	} c2c_cmd_t;

	typedef struct packed {
		logic idx_ok;
		logic is_read;
	} c2c_sts_t;
endpackage

@@ design/covariance_to_correlation_unit.sv @@
// Top level of the covariance-to-correlation unit
//  channel | direction | fields
//  in      | input     | cmd, row, col, elem_value
//  out     | output    | norm_value, saturated
// A write item or an out-of-range read gives its result in the cycle after it is taken.
// An in-range read passes through the store-access states S_RDE, S_RDI,
// S_RDJ and S_CAPJ, a bit-serial multiply, a 32-step square root, a divide
// setup state, a 49-step restoring divide and a final state.
// After reset a clearing pass zeroes every word of the store with in_ready low.
// A new item is taken only once the previous result has been accepted.
`timescale 1ns / 1ps
module covariance_to_correlation_unit #(
	parameter int DIM       = c2c_pkg::DIM_DEF,
	parameter int FRAC_BITS = c2c_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [c2c_pkg::IDX_W-1:0]         row,
	input  logic [c2c_pkg::IDX_W-1:0]         col,
	input  logic signed [c2c_pkg::VAL_W-1:0]  elem_value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [c2c_pkg::VAL_W-1:0]  norm_value,
	output logic                              saturated
);
	import c2c_pkg::*;
	localparam int AW = $clog2(DIM*DIM);

	c2c_cmd_t cmd_c;
	c2c_sts_t sts;
	logic     clr_we;
	logic [AW-1:0] clr_addr;
	logic     idx_ok;

	assign sts.idx_ok  = idx_ok;
	assign sts.is_read = (cmd == CMD_READ);

	c2c_ctrl #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.sts(sts), .cmd_c(cmd_c), .clr_we(clr_we), .clr_addr(clr_addr),
		.out_valid(out_valid), .out_ready(out_ready)
	);

	c2c_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_c(cmd_c), .clr_we(clr_we),
		.clr_addr(clr_addr), .row(row), .col(col), .elem_value(elem_value),
		.norm_value(norm_value), .saturated(saturated), .idx_ok(idx_ok)
	);
endmodule

@@ design/c2c_ram.sv @@
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
module c2c_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

@@ design/c2c_datapath.sv @@
// Datapath: store with clearing write port, product, integer square root and divider
`timescale 1ns / 1ps
module c2c_datapath #(
	parameter int DIM       = c2c_pkg::DIM_DEF,
	parameter int FRAC_BITS = c2c_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  c2c_pkg::c2c_cmd_t          cmd_c,
	input  logic                       clr_we,
	input  logic [$clog2(DIM*DIM)-1:0] clr_addr,
	input  logic [c2c_pkg::IDX_W-1:0]  row,
	input  logic [c2c_pkg::IDX_W-1:0]  col,
	input  logic signed [c2c_pkg::VAL_W-1:0] elem_value,
	output logic signed [c2c_pkg::VAL_W-1:0] norm_value,
	output logic                       saturated,
	output logic                       idx_ok
);
	import c2c_pkg::*;
	localparam int AW    = $clog2(DIM*DIM);
	localparam int NUM_W = VAL_W + 1 + FRAC_BITS;

	logic [AW-1:0]    addr;
	logic [VAL_W-1:0] rdata;
	logic [IDX_W-1:0] ri_q, ci_q;
	logic signed [VAL_W-1:0] elem_q;
	logic [VAL_W-1:0] di_q, dj_q;
	logic [PROD_W-1:0] prod_q;       // shift-add product, later sqrt remainder
	logic [VAL_W-1:0] mcand_q;
	logic [PROD_W-1:0] sq_bit_q, sq_res_q;
	logic [NUM_W-1:0] num_q;
	logic [VAL_W:0]   rem_q;
	logic [VAL_W-1:0] den_q;
	logic             neg_q;
	logic [VAL_W:0]   rem_sh;
	logic [PROD_W-1:0] mag;

	assign idx_ok = (32'(row) < DIM) && (32'(col) < DIM);

	always_comb begin
		unique case (cmd_c.addr_sel)
			ADDR_DI: addr = AW'(32'(ri_q) * DIM + 32'(ri_q));
			ADDR_DJ: addr = AW'(32'(ci_q) * DIM + 32'(ci_q));
			default: addr = AW'(32'(row) * DIM + 32'(col));
		endcase
	end

	c2c_ram #(.WIDTH(VAL_W), .DEPTH(DIM*DIM)) u_ram (
		.clk  (clk),
		.we   (clr_we | cmd_c.ram_we),
		.addr (clr_we ? clr_addr : addr),
		.wdata(clr_we ? '0 : elem_value),
		.rdata(rdata)
	);

	assign rem_sh = {rem_q[VAL_W-1:0], num_q[NUM_W-1]};
	assign mag = {{(PROD_W-VAL_W){1'b0}}, neg_q ? (~elem_q + 1'b1) : elem_q};

	always_ff @(posedge clk) begin
		// Hold the indices of the accepted item for the diagonal reads
		if (cmd_c.cap_idx) begin
			ri_q <= row;
			ci_q <= col;
		end
		if (cmd_c.cap_elem) begin
			elem_q <= rdata;
			neg_q  <= rdata[VAL_W-1];
		end
		// Non-positive diagonal counts as 1.0
		if (cmd_c.cap_di) begin
			di_q <= ($signed(rdata) > 0) ? rdata : VAL_W'(1) << FRAC_BITS;
		end
		if (cmd_c.cap_dj) begin
			dj_q <= ($signed(rdata) > 0) ? rdata : VAL_W'(1) << FRAC_BITS;
		end
		// Multiply: one bit of dj per step
		if (cmd_c.mul_start) begin
			prod_q  <= '0;
			mcand_q <= dj_q;
		end else if (cmd_c.mul_step) begin
			prod_q  <= (prod_q << 1) + (mcand_q[VAL_W-1] ? {32'd0, di_q} : '0);
			mcand_q <= mcand_q << 1;
		end
		// Square root: one result bit per step, starting from bit 62
		if (cmd_c.sqrt_start) begin
			sq_bit_q <= PROD_W'(1) << 62;
			sq_res_q <= '0;
		end else if (cmd_c.sqrt_step) begin
			if (prod_q >= sq_res_q + sq_bit_q) begin
				prod_q   <= prod_q - (sq_res_q + sq_bit_q);
				sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
			end else begin
				sq_res_q <= sq_res_q >> 1;
			end
			sq_bit_q <= sq_bit_q >> 2;
		end
		// Divide: restoring, one quotient bit per step
		if (cmd_c.div_start) begin
			num_q <= NUM_W'(mag) << FRAC_BITS;
			rem_q <= '0;
			den_q <= (sq_res_q[VAL_W-1:0] == '0) ? VAL_W'(1) : sq_res_q[VAL_W-1:0];
		end else if (cmd_c.div_step) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				num_q <= {num_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				num_q <= {num_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_value <= '0;
			saturated  <= 1'b0;
		end else if (cmd_c.res_zero) begin
			norm_value <= '0;
			saturated  <= 1'b0;
		end else if (cmd_c.res_final) begin
			if (neg_q) begin
				if (num_q > NUM_W'(33'h80000000)) begin
					norm_value <= 32'h80000000;
					saturated  <= 1'b1;
				end else begin
					norm_value <= VAL_W'(~num_q + 1'b1);
					saturated  <= 1'b0;
				end
			end else if (num_q > NUM_W'(32'h7fffffff)) begin
				norm_value <= 32'h7fffffff;
				saturated  <= 1'b1;
			end else begin
				norm_value <= num_q[VAL_W-1:0];
				saturated  <= 1'b0;
			end
		end
	end
endmodule

@@ design/c2c_ctrl.sv @@
// Controller: clearing pass and sequencing of write and read items
`timescale 1ns / 1ps
module c2c_ctrl #(
	parameter int DIM       = c2c_pkg::DIM_DEF,
	parameter int FRAC_BITS = c2c_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  c2c_pkg::c2c_sts_t          sts,
	output c2c_pkg::c2c_cmd_t          cmd_c,
	output logic                       clr_we,
	output logic [$clog2(DIM*DIM)-1:0] clr_addr,
	output logic                       out_valid,
	input  logic                       out_ready
);
	import c2c_pkg::*;
	localparam int AW    = $clog2(DIM*DIM);
	localparam int NUM_W = VAL_W + 1 + FRAC_BITS;
	localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RDE = 4'd2, S_RDI = 4'd3,
		S_RDJ = 4'd4, S_CAPJ = 4'd5, S_MUL = 4'd6, S_SQRT = 4'd7, S_DIVS = 4'd8,
		S_DIV = 4'd9, S_FIN = 4'd10;

	logic [3:0]  state_q;
	logic [AW:0] clr_q;
	logic [6:0]  cnt_q;
	logic        accept;

	// Hold next item until the pending result is taken
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign accept   = in_valid && in_ready;
	assign clr_we   = (state_q == S_CLR);
	assign clr_addr = clr_q[AW-1:0];

	always_comb begin
		cmd_c = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd_c.cap_idx  = accept;
				cmd_c.ram_we   = accept && !sts.is_read && sts.idx_ok;
				cmd_c.res_zero = accept && !(sts.is_read && sts.idx_ok);
			end
			// Registered read: each word arrives in the cycle after its address
			S_RDE: begin
				cmd_c.addr_sel = ADDR_DI;
				cmd_c.cap_elem = 1'b1;
			end
			S_RDI: begin
				cmd_c.addr_sel = ADDR_DJ;
				cmd_c.cap_di   = 1'b1;
			end
			S_RDJ:  cmd_c.cap_dj = 1'b1;
			S_CAPJ: ;
			S_MUL: begin
				cmd_c.mul_start = (cnt_q == '0);
				cmd_c.mul_step  = (cnt_q != '0);
				cmd_c.sqrt_start = (cnt_q == 7'(VAL_W));
			end
			S_SQRT: cmd_c.sqrt_step = 1'b1;
			S_DIVS: cmd_c.div_start = 1'b1;
			S_DIV:  cmd_c.div_step  = 1'b1;
			S_FIN:  cmd_c.res_final = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(DIM*DIM - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (sts.is_read && sts.idx_ok) begin
							state_q <= S_RDE;
						end else begin
							out_valid <= 1'b1;
						end
					end
				end
				S_RDE: state_q <= S_RDI;
				S_RDI: state_q <= S_RDJ;
				S_RDJ: state_q <= S_CAPJ;
				S_CAPJ: begin
					state_q <= S_MUL;
					cnt_q   <= '0;
				end
				S_MUL: begin
					// Count past the operand width to cover the multiply start; the sqrt setup shares the last multiply step
					if (cnt_q == 7'(VAL_W)) begin
						state_q <= S_SQRT;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQRT: begin
					if (cnt_q == 7'(PROD_W/2 - 1)) begin
						state_q <= S_DIVS;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIVS: state_q <= S_DIV;
				S_DIV: begin
					if (cnt_q == 7'(NUM_W - 1)) begin
						state_q <= S_FIN;
						cnt_q   <= '0;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_FIN: begin
					state_q   <= S_IDLE;
					out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ design/c2c_checker.sv @@
// Port-level checker for the covariance-to-correlation unit, with bind
`timescale 1ns / 1ps
`include "covariance_to_correlation_unit_macros.svh"
module c2c_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        cmd,
	input logic [31:0] norm_value,
	input logic        saturated
);
	import c2c_pkg::*;

	logic wr_acc;

	assign wr_acc = in_valid && in_ready && (cmd == CMD_WRITE);

	// Never accept an item while a result is pending
	`C2C_ASSERT(a_no_overlap, in_ready |-> !out_valid)
	// A write item yields a zero result
	`C2C_ASSERT_NEXT(a_write_zero, wr_acc, out_valid && norm_value == '0 && !saturated)
	// Saturated results are clipped to an end of the range
	`C2C_ASSERT(a_sat_clip, (out_valid && saturated) |-> (norm_value == 32'h7fffffff || norm_value == 32'h80000000))
	// A pending result holds until taken
	`C2C_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(norm_value))
endmodule

bind covariance_to_correlation_unit c2c_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .cmd(cmd),
	.norm_value(norm_value), .saturated(saturated)
);

@@ verif/tb.sv @@
// Self-checking testbench for the covariance-to-correlation unit
`timescale 1ns / 1ps
module tb;
	import c2c_pkg::*;

	typedef struct {
		logic             op;
		logic [IDX_W-1:0] r;
		logic [IDX_W-1:0] c;
		logic [VAL_W-1:0] v;
	} cov_item_t;

	typedef struct {
		logic [VAL_W-1:0] corr;
		logic             sat;
	} corr_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic cmd = CMD_WRITE;
	logic [IDX_W-1:0] row = '0;
	logic [IDX_W-1:0] col = '0;
	logic signed [VAL_W-1:0] elem_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [VAL_W-1:0] norm_value;
	logic saturated;

	cov_item_t pending_items[$];
	corr_result_t expected_corr[$];
	logic signed [VAL_W-1:0] cov_mirror [DIM_DEF*DIM_DEF];
	int tx_idle = 31;
	int rx_idle = 55;
	int rx_hold_cnt = 0;
	logic rx_hold_go = 1'b0;
	int errors = 0;

	covariance_to_correlation_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .row(row), .col(col), .elem_value(elem_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.norm_value(norm_value), .saturated(saturated)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned acc;
		longint unsigned b;
		acc = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= acc + b) begin
				x = x - (acc + b);
				acc = (acc >> 1) + b;
			end else begin
				acc = acc >> 1;
			end
			b = b >> 2;
		end
		return acc;
	endfunction

	function automatic longint unsigned diag_scale(int k);
		logic signed [VAL_W-1:0] d;
		d = cov_mirror[k*DIM_DEF + k];
		if (d > 0)
			return {32'd0, d};
		return 64'd1 << FRAC_BITS_DEF;
	endfunction

	// Update the mirror on writes and compute the normalized element on reads
	function automatic corr_result_t correlate(cov_item_t it);
		corr_result_t res;
		logic signed [VAL_W-1:0] e;
		longint unsigned mag, den, q;
		res.corr = '0;
		res.sat = 1'b0;
		if (it.op == CMD_WRITE) begin
			cov_mirror[it.r*DIM_DEF + it.c] = it.v;
		end else begin
			e = cov_mirror[it.r*DIM_DEF + it.c];
			mag = (e < 0) ? (64'd0 - {{32{e[31]}}, e}) : {32'd0, e};
			den = int_sqrt(diag_scale(it.r) * diag_scale(it.c));
			if (den == 0)
				den = 1;
			q = (mag << FRAC_BITS_DEF) / den;
			if (e < 0) begin
				if (q > 64'h8000_0000) begin
					q = 64'h8000_0000;
					res.sat = 1'b1;
				end
				res.corr = 32'(64'd0 - q);
			end else begin
				if (q > 64'h7FFF_FFFF) begin
					q = 64'h7FFF_FFFF;
					res.sat = 1'b1;
				end
				res.corr = q[31:0];
			end
		end
		return res;
	endfunction

	task automatic add_item(logic op, int r, int c, logic [VAL_W-1:0] v);
		cov_item_t it;
		it.op = op;
		it.r = r[IDX_W-1:0];
		it.c = c[IDX_W-1:0];
		it.v = v;
		pending_items = {pending_items, it};
	endtask

	task automatic add_random(int n);
		int k, r, sel;
		logic [VAL_W-1:0] v;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(0, 15);
			sel = $urandom_range(0, 9);
			case (sel)
				0: v = $urandom_range(0, 3);
				1: v = $urandom_range(0, 1 << 20);
				2: v = -$urandom_range(0, 1 << 20);
				3, 4: v = $urandom_range(1 << 12, 1 << 24);
				default: v = $urandom;
			endcase
			if ($urandom_range(0, 99) < 45)
				add_item(CMD_READ, r, $urandom_range(0, 15), $urandom);
			else if ($urandom_range(0, 99) < 35)
				add_item(CMD_WRITE, r, r, v);
			else
				add_item(CMD_WRITE, r, $urandom_range(0, 15), v);
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_corr.size() != 0)
			@(posedge clk);
	endtask

	// Driver: hold the item until accepted, then maybe offer the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_corr = {expected_corr, correlate('{cmd, row, col, elem_value})};
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
					cmd <= pending_items[0].op;
					row <= pending_items[0].r;
					col <= pending_items[0].c;
					elem_value <= pending_items[0].v;
					void'(pending_items.pop_front());
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off
	always @(posedge clk) begin
		if (rx_hold_cnt != 0)
			rx_hold_cnt <= rx_hold_cnt - 1;
		else if (rx_hold_go)
			rx_hold_cnt <= 400;
	end

	// Monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_corr.size() == 0) begin
					$display("%0t: unexpected result norm_value=%h saturated=%b",
						$time, norm_value, saturated);
					errors++;
				end else begin
					if (norm_value !== expected_corr[0].corr
							|| saturated !== expected_corr[0].sat) begin
						$display("%0t: expected %h/%b, actual %h/%b",
							$time, expected_corr[0].corr, expected_corr[0].sat,
							norm_value, saturated);
						errors++;
					end
					void'(expected_corr.pop_front());
				end
			end
			out_ready <= (rx_hold_cnt == 0 && !rx_hold_go) && ($urandom_range(0, 99) >= rx_idle);
		end
	end

	initial begin
		int k;
		for (k = 0; k < DIM_DEF*DIM_DEF; k++)
			cov_mirror[k] = '0;
		// Empty store, positive diagonals, negative and zero diagonals, saturation both ways
		add_item(CMD_READ, 0, 0, 32'hFFFF_FFFF);
		add_item(CMD_WRITE, 0, 0, 32'h0001_0000);
		add_item(CMD_WRITE, 1, 1, 32'h0004_0000);
		add_item(CMD_WRITE, 0, 1, 32'h0002_0000);
		add_item(CMD_READ, 0, 1, 32'd0);
		add_item(CMD_WRITE, 2, 2, -32'sd5);
		add_item(CMD_WRITE, 3, 3, 32'd0);
		add_item(CMD_WRITE, 2, 3, 32'h7FFF_FFFF);
		add_item(CMD_READ, 2, 3, 32'd0);
		add_item(CMD_WRITE, 3, 2, 32'h8000_0000);
		add_item(CMD_READ, 3, 2, 32'd0);
		add_item(CMD_WRITE, 4, 4, 32'd1);
		add_item(CMD_WRITE, 5, 5, 32'd1);
		add_item(CMD_WRITE, 4, 5, 32'h8000_0000);
		add_item(CMD_READ, 4, 5, 32'd0);
		add_item(CMD_WRITE, 15, 15, 32'h7FFF_FFFF);
		add_item(CMD_WRITE, 15, 0, 32'hFFFF_FFFF);
		add_item(CMD_READ, 15, 0, 32'd0);
		add_item(CMD_READ, 15, 15, 32'd0);
		add_item(CMD_READ, 2, 2, 32'd0);
		add_item(CMD_READ, 4, 4, 32'd0);
		add_item(CMD_WRITE, 6, 7, 32'd12345);
		add_item(CMD_READ, 7, 6, 32'd0);
		add_random(520);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();
		tx_idle = 55;
		rx_idle = 31;
		add_random(520);
		wait_drained();
		tx_idle = 0;
		rx_idle = 0;
		add_random(510);
		@(posedge clk);
		rx_hold_go <= 1'b1;
		@(posedge clk);
		rx_hold_go <= 1'b0;
		wait_drained();
		repeat (200) @(posedge clk);
		if (errors == 0 && expected_corr.size() == 0)
			$display("** covariance_to_correlation_unit: PASSED **");
		else
			$display("** covariance_to_correlation_unit: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** covariance_to_correlation_unit: FAILED **");
		$finish;
	end
endmodule
